// File: design/swm_pkg.sv
// Shared types and constants of the sliding window median filter.
package swm_pkg;

    // Register index decoded from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Width and reset value of the window_size register
    localparam int          CFG_BITS     = 5;
    localparam logic [4:0]  WINDOW_RESET = 5'd3;

    // Control handed from one cell to the next one up the chain
    typedef struct packed {
        logic valid;    // compacted entry of the lower cell is occupied
        logic ins;      // new sample sits at or below the lower cell
        logic dropped;  // the oldest entry was found at or below the lower cell
    } t_link;

    // Controls broadcast to every cell
    typedef struct packed {
        logic load;     // a sample transaction is taken this cycle
        logic clear;    // empty the window
        logic restart;  // treat all stored entries as gone for this sample
        logic full;     // the window is full, so the oldest entry leaves
    } t_bcast;

endpackage

// File: design/sliding_window_median.sv
// Top level of the sliding window median filter: cell chain, fill count, median output.
//
// Keeps the last window_size samples (1..WINDOW_MAX, register at address 0; 0 acts as 1,
// larger values act as WINDOW_MAX) in ascending order in a chain of cells, one entry per
// cell. A sample transaction updates all cells together: the oldest entry leaves
// and the new sample drops into its sorted place. Once the window is full each sample
// yields twice the median (sum of the two middle values for an even window); it waits as
// pending until the middle cells load the output register. While the window fills, a
// sample can be taken on every cycle; a sample that yields a median closes the input for
// the next cycle, so a full window takes no sample while a median is pending. The input
// stays closed longer only while a computed median waits behind an unread result.
// A set restart flag empties the window before its sample; any write of window_size
// empties it too.
module sliding_window_median #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Sample channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                         i_restart,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SAMPLE_BITS:0]  o_median_x2,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int SW = SAMPLE_BITS;
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int XW = (CW > swm_pkg::CFG_BITS) ? CW : swm_pkg::CFG_BITS;

    logic [swm_pkg::CFG_BITS-1:0] r_cfg;
    logic [CW-1:0]                r_fill;
    logic [CW-1:0]                n_fill;
    logic                         r_pend;
    logic                         r_out_valid;
    logic signed [SW:0]           r_out;

    logic                         cfg_wr;
    logic                         accept;
    logic                         move;
    logic [XW-1:0]                cfg_x;
    logic [CW-1:0]                w_eff;
    logic [AW-1:0]                w_last;
    logic [AW-1:0]                hi_idx;
    logic [AW-1:0]                lo_idx;
    logic [CW-1:0]                base_fill;
    logic                         full;
    logic                         result;
    swm_pkg::t_bcast              bc;

    swm_pkg::t_link               cell_link  [WINDOW_MAX];
    logic signed [SW-1:0]         cell_cval  [WINDOW_MAX];
    logic [AW-1:0]                cell_cage  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]        cell_valid;
    logic signed [SW-1:0]         cell_value [WINDOW_MAX];
    logic [AW-1:0]                cell_age   [WINDOW_MAX];

    logic signed [SW-1:0]         tap_lo;
    logic signed [SW-1:0]         tap_hi;
    logic signed [SW:0]           median;

    // Configuration register
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= swm_pkg::WINDOW_RESET;
        end else if (cfg_wr && (paddr[2] == swm_pkg::REG_WINDOW_SIZE)) begin
            r_cfg <= pwdata[swm_pkg::CFG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
            prdata = 32'(r_cfg);
        end
    end

    // Effective window size and the cell taps it selects
    always_comb begin
        cfg_x = XW'(r_cfg);
        if (cfg_x == '0) begin
            w_eff = CW'(1);
        end else if (cfg_x > XW'(WINDOW_MAX)) begin
            w_eff = CW'(WINDOW_MAX);
        end else begin
            w_eff = cfg_x[CW-1:0];
        end
        w_last = AW'(w_eff - CW'(1));
        hi_idx = AW'(w_eff >> 1);
        lo_idx = w_eff[0] ? hi_idx : hi_idx - AW'(1);
    end

    // Fill bookkeeping for the sample being taken
    assign o_ready = !r_pend;
    assign accept  = i_valid && o_ready;

    always_comb begin
        base_fill = i_restart ? '0 : r_fill;
        full      = (base_fill >= w_eff);
        n_fill    = full ? base_fill : base_fill + CW'(1);
        result    = (n_fill == w_eff);
        bc        = '{load: accept, clear: cfg_wr, restart: i_restart, full: full};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // Cell chain
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_pkg::t_link       lo_link;
        logic signed [SW-1:0] lo_value;
        logic [AW-1:0]        lo_age;
        logic                 up_valid;
        logic signed [SW-1:0] up_value;
        logic [AW-1:0]        up_age;

        if (g == 0) begin : g_bottom
            assign lo_link  = '0;
            assign lo_value = '0;
            assign lo_age   = '0;
        end else begin : g_mid
            assign lo_link  = cell_link[g-1];
            assign lo_value = cell_cval[g-1];
            assign lo_age   = cell_cage[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_top
            assign up_valid = 1'b0;
            assign up_value = '0;
            assign up_age   = '0;
        end else begin : g_below
            assign up_valid = cell_valid[g+1];
            assign up_value = cell_value[g+1];
            assign up_age   = cell_age[g+1];
        end

        swm_cell #(
            .SW(SW),
            .AW(AW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_bc       (bc),
            .i_sample   (i_sample),
            .i_w_last   (w_last),
            .i_lo_link  (lo_link),
            .i_lo_value (lo_value),
            .i_lo_age   (lo_age),
            .i_up_valid (up_valid),
            .i_up_value (up_value),
            .i_up_age   (up_age),
            .o_link     (cell_link[g]),
            .o_c_value  (cell_cval[g]),
            .o_c_age    (cell_cage[g]),
            .o_valid    (cell_valid[g]),
            .o_value    (cell_value[g]),
            .o_age      (cell_age[g])
        );
    end

    // Pick the middle cells and sum them
    always_comb begin
        tap_lo = '0;
        tap_hi = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            if (AW'(k) == lo_idx) begin
                tap_lo = tap_lo | cell_value[k];
            end
            if (AW'(k) == hi_idx) begin
                tap_hi = tap_hi | cell_value[k];
            end
        end
        median = (SW+1)'(tap_lo) + (SW+1)'(tap_hi);
    end

    // Median pending, then output register
    assign move = r_pend && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && result) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= median;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_median_x2 = r_out;

`ifndef ASSERT_OFF
    // Occupied cells match the fill count
    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_fill))
        else $error("cell occupancy differs from fill count");

    // Fill count never exceeds the window
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count above window size");

    // A full window always finds its oldest entry
    a_oldest_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full |-> cell_link[WINDOW_MAX-1].dropped)
        else $error("oldest entry not found in full window");

    // A completed window queues a median
    a_result_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && result && !cfg_wr |=> r_pend || r_out_valid)
        else $error("median not queued");
`endif

endmodule

// File: design/swm_cell.sv
// One cell of the sorted window: holds one entry and its age.
module swm_cell #(
    parameter int SW = 16,
    parameter int AW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swm_pkg::t_bcast      i_bc,
    input  logic signed [SW-1:0] i_sample,
    input  logic [AW-1:0]        i_w_last,
    input  swm_pkg::t_link       i_lo_link,
    input  logic signed [SW-1:0] i_lo_value,
    input  logic [AW-1:0]        i_lo_age,
    input  logic                 i_up_valid,
    input  logic signed [SW-1:0] i_up_value,
    input  logic [AW-1:0]        i_up_age,
    output swm_pkg::t_link       o_link,
    output logic signed [SW-1:0] o_c_value,
    output logic [AW-1:0]        o_c_age,
    output logic                 o_valid,
    output logic signed [SW-1:0] o_value,
    output logic [AW-1:0]        o_age
);

    logic                 r_valid;
    logic signed [SW-1:0] r_value;
    logic [AW-1:0]        r_age;
    logic                 n_valid;
    logic signed [SW-1:0] n_value;
    logic [AW-1:0]        n_age;

    logic                 own_valid;
    logic                 up_valid;
    logic                 drop_here;
    logic                 dropped;
    logic                 c_valid;
    logic signed [SW-1:0] c_value;
    logic [AW-1:0]        c_age;
    logic                 ins;

    // Drop the oldest entry: cells at and above it take their upper neighbor
    always_comb begin
        own_valid = r_valid && !i_bc.restart;
        up_valid  = i_up_valid && !i_bc.restart;
        drop_here = own_valid && i_bc.full && (r_age == i_w_last);
        dropped   = i_lo_link.dropped || drop_here;
        if (dropped) begin
            c_valid = up_valid;
            c_value = i_up_value;
            c_age   = i_up_age;
        end else begin
            c_valid = own_valid;
            c_value = r_value;
            c_age   = r_age;
        end
        ins = !c_valid || (c_value > i_sample);
    end

    // Insert the sample: shift up above the insertion point, age survivors
    always_comb begin
        if (i_lo_link.ins) begin
            n_valid = i_lo_link.valid;
            n_value = i_lo_value;
            n_age   = i_lo_age + AW'(1);
        end else if (ins) begin
            n_valid = 1'b1;
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_valid = c_valid;
            n_value = c_value;
            n_age   = c_age + AW'(1);
        end
    end

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_bc.clear) begin
            r_valid <= 1'b0;
        end else if (i_bc.load) begin
            r_valid <= n_valid;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_bc.load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link    = '{valid: c_valid, ins: ins, dropped: dropped};
    assign o_c_value = c_value;
    assign o_c_age   = c_age;
    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_age     = r_age;

endmodule

// File: dv/sliding_window_median_tb.sv
// Self-checking testbench for the sliding window median filter: sorted-window predictor.
module sliding_window_median_tb;

    localparam int WINDOW_MAX    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int SEGMENT_ITEMS = 52;

    localparam logic [2:0] WINDOW_SIZE_ADDR = {swm_pkg::REG_WINDOW_SIZE, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_restart;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS:0]   o_median_x2;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // Predicted window: ascending values with their ages, plus the window_size register
    logic signed [SAMPLE_BITS-1:0] win_values [WINDOW_MAX];
    int                            win_ages [WINDOW_MAX];
    int                            win_fill;
    logic [swm_pkg::CFG_BITS-1:0]  size_reg;
    logic signed [SAMPLE_BITS:0]   median_queue [$];
    logic signed [SAMPLE_BITS:0]   expected_median;

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int mismatch_count;
    int samples_sent;
    int medians_checked;
    int config_writes;

    sliding_window_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_median_x2 (o_median_x2),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Drop the oldest entry when full, age the rest, insert in sorted place, predict median
    task automatic update_window(input logic signed [SAMPLE_BITS-1:0] s, input logic rst_flag);
        int w;
        int pos;
        int oldest;
        logic signed [SAMPLE_BITS:0] m;
        w = (size_reg == 0) ? 1 : ((size_reg > WINDOW_MAX) ? WINDOW_MAX : int'(size_reg));
        if (rst_flag) begin
            win_fill = 0;
        end
        while (win_fill >= w) begin
            pos = 0;
            oldest = 0;
            for (int i = 0; i < win_fill; i++) begin
                if (win_ages[i] >= oldest) begin
                    oldest = win_ages[i];
                    pos = i;
                end
            end
            for (int i = pos; i + 1 < win_fill; i++) begin
                win_values[i] = win_values[i + 1];
                win_ages[i] = win_ages[i + 1];
            end
            win_fill--;
        end
        for (int i = 0; i < win_fill; i++) begin
            win_ages[i]++;
        end
        pos = win_fill;
        while (pos > 0 && win_values[pos - 1] > s) begin
            win_values[pos] = win_values[pos - 1];
            win_ages[pos] = win_ages[pos - 1];
            pos--;
        end
        win_values[pos] = s;
        win_ages[pos] = 0;
        win_fill++;
        if (win_fill == w) begin
            if (w % 2 == 1) begin
                m = {win_values[w / 2], 1'b0};
            end else begin
                m = {win_values[w / 2 - 1][SAMPLE_BITS-1], win_values[w / 2 - 1]}
                  + {win_values[w / 2][SAMPLE_BITS-1], win_values[w / 2]};
            end
            median_queue = {median_queue, m};
        end
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 85;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 85;
            end
            default: begin
                send_idle_pct = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    // Present one sample and hold it until the transaction is taken
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic rst_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        i_restart <= rst_flag;
        do @(posedge i_clk); while (!o_ready);
        update_window(s, rst_flag);
        samples_sent++;
    endtask

    // Stop sending, wait for every predicted median, then let in-flight samples settle
    task automatic wait_window_idle();
        i_valid <= 1'b0;
        while (median_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_window_size_reg();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= WINDOW_SIZE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[swm_pkg::CFG_BITS-1:0] !== size_reg) begin
            note_error($sformatf("window_size read %0d, expected %0d",
                                 prdata[swm_pkg::CFG_BITS-1:0], size_reg));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write window_size (this empties the window), then read it back
    task automatic write_window_size(input logic [swm_pkg::CFG_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WINDOW_SIZE_ADDR;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_reg = value;
        win_fill = 0;
        config_writes++;
        check_window_size_reg();
    endtask

    // Reset value of window_size and the sample extremes
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        check_window_size_reg();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    // Restart on a full window and on a partly filled one
    task automatic test_restart_flag();
        set_idling(IDLE_BOTH);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd200, 1'b1);
        send_sample(16'sd300, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd7, 1'b1);
        send_sample(16'sd8, 1'b1);
        send_sample(16'sd9, 1'b0);
    endtask

    // Duplicates in the window
    task automatic test_equal_samples();
        set_idling(IDLE_NONE);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd5, 1'b0);
    endtask

    // Size zero acts as one; even window at both output extremes
    task automatic test_size_limits();
        wait_window_idle();
        write_window_size(5'd0);
        send_sample(16'sd11, 1'b0);
        send_sample(-16'sd11, 1'b0);
        wait_window_idle();
        write_window_size(5'd2);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);
    endtask

    // Random samples over a sweep of window sizes and idle modes
    task automatic test_random_windows();
        int sizes [12];
        int pick;
        logic signed [SAMPLE_BITS-1:0] s;
        logic rst_flag;
        sizes = '{16, 0, 31, 1, 2, 17, 7, 8, 4, 15, 3, 12};
        for (int seg = 0; seg < 12; seg++) begin
            wait_window_idle();
            write_window_size(swm_pkg::CFG_BITS'(sizes[seg]));
            set_idling(t_idle_mode'(seg % 4));
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                // hold off mid-segment until every median is out
                if (seg % 3 == 1 && n == SEGMENT_ITEMS / 2) begin
                    wait_window_idle();
                end
                pick = $urandom_range(99);
                if (pick < 8) begin
                    s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end else if (pick < 35) begin
                    s = SAMPLE_BITS'($urandom_range(6) - 3);
                end else begin
                    s = SAMPLE_BITS'($urandom);
                end
                rst_flag = ($urandom_range(99) < 4);
                send_sample(s, rst_flag);
            end
        end
    endtask

    // Check each result transaction, track activity, randomize receiver stalls
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            medians_checked++;
            if (median_queue.size() == 0) begin
                note_error($sformatf("median_x2 %0d with none expected", o_median_x2));
            end else begin
                expected_median = median_queue.pop_front();
                if (o_median_x2 !== expected_median) begin
                    note_error($sformatf("median_x2 expected %0d, got %0d",
                                         expected_median, o_median_x2));
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when nothing moves for too long
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_sample <= '0;
        i_restart <= 1'b0;
        i_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        size_reg = swm_pkg::WINDOW_RESET;
        win_fill = 0;
        idle_cycles = 0;
        mismatch_count = 0;
        samples_sent = 0;
        medians_checked = 0;
        config_writes = 0;
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_restart_flag();
        test_equal_samples();
        test_size_limits();
        test_random_windows();

        wait_window_idle();
        if (median_queue.size() != 0) begin
            note_error($sformatf("%0d medians never arrived", median_queue.size()));
        end
        $display("Covered %0d samples and %0d medians over %0d window_size writes,",
                 samples_sent, medians_checked, config_writes);
        $display("with restarts, duplicates, size extremes and all four idle modes.");
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
